@@ hdl/sor_pkg.sv @@
package sor_pkg;

    localparam int MAX_EQUATIONS_DEF = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int RELAX_BITS        = 16;

    localparam int OPERAND_W  = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Input commands.
    localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] CMD_LOAD_RHS    = 2'd1;
    localparam logic [1:0] CMD_LOAD_GUESS  = 2'd2;
    localparam logic [1:0] CMD_START       = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELAXATION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS  = 3'd3;

    localparam logic [4:0]  ACTIVE_SIZE_RST = 5'd16;
    localparam logic [17:0] RELAXATION_RST  = 18'd65536;
    localparam logic [31:0] THRESHOLD_RST   = 32'd0;
    localparam logic [15:0] MAX_SWEEPS_RST  = 16'd1000;

    localparam logic signed [63:0] SAT64_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT64_NEG = -64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Saturating add to +-(2^63-1).
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SAT64_POS))
            return SAT64_POS;
        else if (s < 65'(SAT64_NEG))
            return SAT64_NEG;
        else
            return s[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

@@ hdl/sor_cmd_if.sv @@
interface sor_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] operand_value;

    modport source (output valid, command, row_index, col_index, operand_value, input ready);
    modport sink   (input valid, command, row_index, col_index, operand_value, output ready);
endinterface

@@ hdl/sor_res_if.sv @@
interface sor_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         element_index;
    logic signed [31:0] solution_value;
    logic [15:0]        sweep_count;
    logic               converged;
    logic               zero_pivot;
    logic               last_element;

    modport source (output valid, element_index, solution_value, sweep_count, converged,
                    zero_pivot, last_element, input ready);
    modport sink   (input valid, element_index, solution_value, sweep_count, converged,
                    zero_pivot, last_element, output ready);
endinterface

@@ hdl/sor_ram.sv @@
module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ hdl/sor_div.sv @@
// Signed 64 by 32 bit division, truncating toward zero, one quotient bit per cycle.
module sor_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [63:0]    num,
    input  logic signed [31:0]    den,
    output sor_pkg::div_status_t  status,
    output logic signed [63:0]    quot
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dmag_reg, dmag_next;
    logic        neg_reg, neg_next;
    logic [32:0] shifted;
    logic        fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, dvd_reg[63]};
        fits      = shifted >= {1'b0, dmag_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = num[63] ? 64'(-num) : 64'(num);
            rem_next  = '0;
            dmag_next = den[31] ? 32'(-den) : 32'(den);
            neg_next  = num[63] ^ den[31];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(shifted - {1'b0, dmag_reg}) : shifted[31:0];
            dvd_next = {dvd_reg[62:0], fits};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
endmodule

@@ hdl/sor_linear_solver.sv @@
// Successive over-relaxation solver. Load matrix entries, right-side entries and a
// starting guess one per transfer (one load transfer per cycle while idle), then send a
// start command; further commands are held until the last result is issued. One result
// transfer per active element carries the solution, the sweep count and the status flags.
// Each row update streams the row of the matrix memory and the solution memory through
// the product accumulator, then the bit-serial divider forms the quotient by the pivot.
// A sweep is n row updates for n active equations. A solve first scans the n diagonal
// entries; if one is zero it runs no sweeps and flags a zero pivot, else it runs sweeps
// until the summed squared change falls to the threshold or the sweep cap is reached.
// Memories need no clearing after reset.
module sor_linear_solver #(
    parameter int MAX_EQUATIONS = sor_pkg::MAX_EQUATIONS_DEF,
    parameter int FRACTION_BITS = sor_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sor_cmd_if.sink                            cmd,
    sor_res_if.source                          res,
    input  logic                               cfg_we,
    input  logic [sor_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sor_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int IW = $clog2(MAX_EQUATIONS);
    localparam int CW = $clog2(MAX_EQUATIONS + 1);
    localparam int MD = MAX_EQUATIONS * MAX_EQUATIONS;
    localparam int MW = $clog2(MD);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PIV     = 4'd1;
    localparam logic [3:0] S_ACC     = 4'd2;
    localparam logic [3:0] S_NUM     = 4'd3;
    localparam logic [3:0] S_DIVGO   = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_RELAX   = 4'd6;
    localparam logic [3:0] S_UPD     = 4'd7;
    localparam logic [3:0] S_SQ      = 4'd8;
    localparam logic [3:0] S_CHG     = 4'd9;
    localparam logic [3:0] S_EMIT_RD = 4'd10;
    localparam logic [3:0] S_EMIT_WR = 4'd11;

    // Configuration registers.
    logic [4:0]  active_size_reg;
    logic [17:0] relax_reg;
    logic [31:0] thresh_reg;
    logic [15:0] max_sweeps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= sor_pkg::ACTIVE_SIZE_RST;
            relax_reg       <= sor_pkg::RELAXATION_RST;
            thresh_reg      <= sor_pkg::THRESHOLD_RST;
            max_sweeps_reg  <= sor_pkg::MAX_SWEEPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sor_pkg::REG_ACTIVE_SIZE: active_size_reg <= cfg_data[4:0];
                sor_pkg::REG_RELAXATION:  relax_reg       <= cfg_data[17:0];
                sor_pkg::REG_THRESHOLD:   thresh_reg      <= cfg_data[31:0];
                sor_pkg::REG_MAX_SWEEPS:  max_sweeps_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Effective size and sweep cap.
    logic [CW-1:0] n_eff;
    logic [15:0]   cap;

    always_comb
    begin
        if (active_size_reg == 5'd0)
            n_eff = CW'(1);
        else if (32'(active_size_reg) > MAX_EQUATIONS)
            n_eff = CW'(MAX_EQUATIONS);
        else
            n_eff = CW'(active_size_reg);
        cap = (max_sweeps_reg == 16'd0) ? 16'd1 : max_sweeps_reg;
    end

    // Sequencer state.
    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        j1_reg;
    logic                 v1_reg, v2_reg;
    logic                 piv_bad_reg, piv_bad_next;
    logic                 conv_reg, conv_next;
    logic [15:0]          sweep_reg, sweep_next;
    logic [63:0]          chg_reg, chg_next;
    logic signed [63:0]   acc_reg, acc_next;
    logic signed [63:0]   prod_reg;
    logic signed [31:0]   aii_reg, old_reg, b_reg;
    logic signed [63:0]   num_reg;
    logic signed [32:0]   delta_reg;
    logic signed [51:0]   rprod_reg;
    logic signed [32:0]   d_reg;
    logic [63:0]          sq_reg;
    logic signed [31:0]   relaxed;
    logic [64:0]          chg_sum;

    // Memories.
    logic                 mat_we, rhs_we, sol_we;
    logic [MW-1:0]        mat_waddr, mat_raddr;
    logic [IW-1:0]        sol_waddr, sol_raddr, rhs_waddr;
    logic [31:0]          sol_wdata;
    logic [31:0]          mat_rd, rhs_rd, sol_rd;

    logic load_ok;
    logic cmd_xfer;
    logic issue;
    logic out_free;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign load_ok   = 32'(cmd.row_index) < MAX_EQUATIONS;
    assign out_free  = !res.valid || res.ready;
    assign issue     = ((state_reg == S_PIV) || (state_reg == S_ACC)) && (j_reg < n_eff);

    assign mat_we    = cmd_xfer && load_ok && (cmd.command == sor_pkg::CMD_LOAD_MATRIX)
                       && (32'(cmd.col_index) < MAX_EQUATIONS);
    assign mat_waddr = MW'(32'(cmd.row_index) * MAX_EQUATIONS + 32'(cmd.col_index));
    assign rhs_we    = cmd_xfer && load_ok && (cmd.command == sor_pkg::CMD_LOAD_RHS);
    assign rhs_waddr = IW'(cmd.row_index);

    assign relaxed = sor_pkg::clamp32(64'(old_reg) + 64'(rprod_reg >>> sor_pkg::RELAX_BITS));

    always_comb
    begin
        if (state_reg == S_UPD)
        begin
            sol_we    = 1'b1;
            sol_waddr = i_reg[IW-1:0];
            sol_wdata = relaxed;
        end
        else
        begin
            sol_we    = cmd_xfer && load_ok && (cmd.command == sor_pkg::CMD_LOAD_GUESS);
            sol_waddr = IW'(cmd.row_index);
            sol_wdata = cmd.operand_value;
        end
        if (state_reg == S_PIV)
            mat_raddr = MW'(32'(j_reg[IW-1:0]) * MAX_EQUATIONS + 32'(j_reg[IW-1:0]));
        else
            mat_raddr = MW'(32'(i_reg[IW-1:0]) * MAX_EQUATIONS + 32'(j_reg[IW-1:0]));
        sol_raddr = j_reg[IW-1:0];
    end

    sor_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
        .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(cmd.operand_value),
        .raddr(mat_raddr), .rdata(mat_rd)
    );

    sor_ram #(.WIDTH(32), .DEPTH(MAX_EQUATIONS)) u_rhs (
        .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(cmd.operand_value),
        .raddr(i_reg[IW-1:0]), .rdata(rhs_rd)
    );

    sor_ram #(.WIDTH(32), .DEPTH(MAX_EQUATIONS)) u_sol (
        .clk(clk), .we(sol_we), .waddr(sol_waddr), .wdata(sol_wdata),
        .raddr(sol_raddr), .rdata(sol_rd)
    );

    // Divider for the quotient by the pivot.
    sor_pkg::div_status_t div_st;
    logic signed [63:0]   div_q;

    sor_div u_div (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_DIVGO),
        .num(num_reg), .den(aii_reg), .status(div_st), .quot(div_q)
    );

    // Output register.
    logic              res_valid_reg, res_valid_next;
    logic [3:0]        res_idx_reg;
    logic signed [31:0] res_val_reg;
    logic              res_last_reg;
    logic [15:0]       res_sweep_reg;
    logic              res_conv_reg;
    logic              res_piv_reg;

    assign chg_sum = {1'b0, chg_reg} + {1'b0, sq_reg};

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        piv_bad_next   = piv_bad_reg;
        conv_next      = conv_reg;
        sweep_next     = sweep_reg;
        chg_next       = chg_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg && !res.ready;
        if (issue)
            j_next = j_reg + CW'(1);
        if (v2_reg)
            acc_next = sor_pkg::sat_add64(acc_reg, prod_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer && (cmd.command == sor_pkg::CMD_START))
                begin
                    state_next   = S_PIV;
                    j_next       = '0;
                    piv_bad_next = 1'b0;
                    conv_next    = 1'b0;
                    sweep_next   = '0;
                    chg_next     = '0;
                end
            end
            S_PIV:
            begin
                if (v1_reg && (mat_rd == 32'd0))
                    piv_bad_next = 1'b1;
                if (!issue && !v1_reg)
                begin
                    i_next = '0;
                    j_next = '0;
                    if (piv_bad_reg)
                        state_next = S_EMIT_RD;
                    else
                    begin
                        state_next = S_ACC;
                        acc_next   = '0;
                    end
                end
            end
            S_ACC:
            begin
                if (!issue && !v1_reg && !v2_reg)
                    state_next = S_NUM;
            end
            S_NUM:   state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_st.done)
                    state_next = S_RELAX;
            end
            S_RELAX: state_next = S_UPD;
            S_UPD:   state_next = S_SQ;
            S_SQ:    state_next = S_CHG;
            S_CHG:
            begin
                chg_next = chg_sum[64] ? '1 : chg_sum[63:0];
                j_next   = '0;
                acc_next = '0;
                if (i_reg + CW'(1) == n_eff)
                begin
                    sweep_next = sweep_reg + 16'd1;
                    i_next     = '0;
                    if (chg_next <= 64'(thresh_reg))
                    begin
                        conv_next  = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                    else if (sweep_next >= cap)
                        state_next = S_EMIT_RD;
                    else
                    begin
                        chg_next   = '0;
                        state_next = S_ACC;
                    end
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_ACC;
                end
            end
            S_EMIT_RD:
            begin
                j_next = i_reg;
                if (out_free)
                    state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                res_valid_next = 1'b1;
                i_next         = i_reg + CW'(1);
                j_next         = i_reg + CW'(1);
                if (i_reg + CW'(1) == n_eff)
                    state_next = S_IDLE;
                else
                    state_next = S_EMIT_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            piv_bad_reg   <= 1'b0;
            conv_reg      <= 1'b0;
            sweep_reg     <= '0;
            chg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg && (state_reg == S_ACC) && (j1_reg != i_reg);
            piv_bad_reg   <= piv_bad_next;
            conv_reg      <= conv_next;
            sweep_reg     <= sweep_next;
            chg_reg       <= chg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        j1_reg   <= j_reg;
        prod_reg <= $signed(mat_rd) * $signed(sol_rd);
        if (v1_reg && (state_reg == S_ACC))
        begin
            b_reg <= rhs_rd;
            if (j1_reg == i_reg)
            begin
                aii_reg <= mat_rd;
                old_reg <= sol_rd;
            end
        end
        if (state_reg == S_NUM)
            num_reg <= sor_pkg::sat_add64(64'(b_reg) <<< FRACTION_BITS, -acc_reg);
        if (div_st.done)
            delta_reg <= 33'(sor_pkg::clamp32(div_q)) - 33'(old_reg);
        if (state_reg == S_RELAX)
            rprod_reg <= delta_reg * $signed({1'b0, relax_reg});
        if (state_reg == S_UPD)
            d_reg <= 33'(relaxed) - 33'(old_reg);
        if (state_reg == S_SQ)
            sq_reg <= 64'(d_reg * d_reg);
        if (state_reg == S_EMIT_WR)
        begin
            res_idx_reg   <= 4'(i_reg);
            res_val_reg   <= sol_rd;
            res_last_reg  <= (i_reg + CW'(1) == n_eff);
            res_sweep_reg <= sweep_reg;
            res_conv_reg  <= conv_reg;
            res_piv_reg   <= piv_bad_reg;
        end
    end

    // The status fields are copied into the output register with each element, so a
    // new solve that starts while the final result still waits cannot disturb it.
    assign res.valid          = res_valid_reg;
    assign res.element_index  = res_idx_reg;
    assign res.solution_value = res_val_reg;
    assign res.sweep_count    = res_sweep_reg;
    assign res.converged      = res_conv_reg;
    assign res.zero_pivot     = res_piv_reg;
    assign res.last_element   = res_last_reg;

    // An aborted solve reports no sweeps and never reports convergence.
    a_pivot_status: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.zero_pivot |-> (res.sweep_count == 16'd0) && !res.converged)
        else $error("zero pivot result with sweeps or convergence");

    // The divider is started only when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVGO) |-> !div_st.busy)
        else $error("divider started while busy");

    // The last element of a run is the top active index.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last_element |-> res.element_index == 4'(n_eff - CW'(1)))
        else $error("last element flag on wrong index");

    // A result waiting for its transfer keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> $stable(res.solution_value))
        else $error("waiting result changed");
endmodule
